// ===== hdl/est_pkg.sv =====
package est_pkg;

    localparam int unsigned INDEX_W = 10;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 11;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [INDEX_W-1:0] entry_index;
        logic [DATA_W-1:0]  key_value;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } rsp_t;

endpackage

// ===== hdl/exponential_search_sorted_table.sv =====
// Channel   Handshake                      Payload
// request   start, accepted when !busy     req    (est_pkg::req_t)
// config    cfg_valid / cfg_ready          cfg_data (entry_count)
// result    result_valid, one-cycle strobe result (est_pkg::rsp_t)
//
// A write request leaves busy low. A search probes the table one entry at a time
// through the single read port of the key memory: the probe of
// entry 0, up to log2(n) doubling probes, one setup step and up to about log2(n)
// binary probes. busy falls in the same cycle as result_valid rises.
// An empty table answers in the next cycle without raising busy.
// Reset clears the controller and entry_count; the key memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module exponential_search_sorted_table #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned KEY_WIDTH   = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  est_pkg::req_t                req,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [est_pkg::POS_W-1:0]    cfg_data,
    output logic                         result_valid,
    output est_pkg::rsp_t                result
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [est_pkg::POS_W-1:0] entry_count_reg;
    logic [CW-1:0]             count_eff;
    logic [KEY_WIDTH-1:0]      key_in;
    logic                      accept;
    logic                      wr_en;
    logic                      search_go;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [KEY_WIDTH-1:0]      rd_data;

    assign accept    = start && !busy;
    assign key_in    = KEY_WIDTH'(req.key_value);
    assign wr_en     = accept && (req.req_type == est_pkg::REQ_WRITE)
                       && (32'(req.entry_index) < TABLE_DEPTH);
    assign search_go = accept && (req.req_type == est_pkg::REQ_SEARCH);
    assign cfg_ready = !busy;

    // A count above the table depth is saturated to the depth.
    always_comb
    begin
        if (32'(entry_count_reg) > TABLE_DEPTH)
        begin
            count_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            count_eff = CW'(entry_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    est_key_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .KW    (KEY_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(req.entry_index)),
        .wr_data (key_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    est_search_ctrl #(
        .AW (AW),
        .CW (CW),
        .KW (KEY_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .search_go    (search_go),
        .search_key   (key_in),
        .search_count (count_eff),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== hdl/est_key_ram.sv =====
module est_key_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned KW    = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [KW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [KW-1:0] rd_data
);

    logic [KW-1:0] mem [DEPTH];
    logic [KW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/est_search_ctrl.sv =====
module est_search_ctrl #(
    parameter int unsigned AW = 10,
    parameter int unsigned CW = 11,
    parameter int unsigned KW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          search_go,
    input  logic [KW-1:0] search_key,
    input  logic [CW-1:0] search_count,
    output logic          busy,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [KW-1:0] rd_data,
    output logic          result_valid,
    output est_pkg::rsp_t result
);

    localparam int unsigned PW = CW + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FIRST  = 5'b00010,
        S_DOUBLE = 5'b00100,
        S_BSETUP = 5'b01000,
        S_BIN    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [KW-1:0] key_reg, key_next;
    logic [CW-1:0] n_reg, n_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] step_reg, step_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic          result_valid_reg, result_valid_next;
    est_pkg::rsp_t result_reg, result_next;

    // Shared compare unit: every probe of the table goes through it.
    logic          key_gt;
    logic          key_eq;

    logic [PW-1:0] p_adv;
    logic          p_adv_in;
    logic [AW-1:0] n_last;
    logic [AW:0]   sum_setup;
    logic [AW:0]   sum_up;
    logic [AW:0]   sum_down;
    logic [AW-1:0] mid_plus;
    logic [AW-1:0] mid_minus;

    assign key_gt = rd_data < key_reg;
    assign key_eq = rd_data == key_reg;

    assign p_adv     = p_reg + step_reg;
    assign p_adv_in  = p_adv < PW'(n_reg);
    assign n_last    = AW'(n_reg - CW'(1));
    assign mid_plus  = mid_reg + AW'(1);
    assign mid_minus = mid_reg - AW'(1);
    // Next midpoints for both compare outcomes are formed beside the compare.
    assign sum_setup = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign sum_up    = {1'b0, mid_plus} + {1'b0, hi_reg};
    assign sum_down  = {1'b0, lo_reg} + {1'b0, mid_minus};

    always_comb
    begin
        state_next        = state_reg;
        key_next          = key_reg;
        n_next            = n_reg;
        p_next            = p_reg;
        step_next         = step_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (search_go)
                begin
                    key_next  = search_key;
                    n_next    = search_count;
                    p_next    = '0;
                    step_next = PW'(1);
                    if (search_count == '0)
                    begin
                        result_valid_next    = 1'b1;
                        result_next.found    = 1'b0;
                        result_next.position = '0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST, S_DOUBLE:
            begin
                if (key_gt)
                begin
                    if (p_adv_in)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = p_adv[AW-1:0];
                        p_next     = p_adv;
                        step_next  = step_reg << 1;
                        state_next = S_DOUBLE;
                    end
                    else
                    begin
                        lo_next    = p_reg[AW-1:0];
                        hi_next    = n_last;
                        state_next = S_BSETUP;
                    end
                end
                else if (state_reg == S_FIRST)
                begin
                    // Entry 0 already reaches the key, so it alone decides.
                    result_valid_next    = 1'b1;
                    result_next.found    = key_eq;
                    result_next.position = key_eq ? '0 : est_pkg::POS_W'(n_reg);
                    state_next           = S_IDLE;
                end
                else
                begin
                    lo_next    = AW'(p_reg - (step_reg >> 1));
                    hi_next    = p_reg[AW-1:0];
                    state_next = S_BSETUP;
                end
            end
            S_BSETUP:
            begin
                mid_next   = sum_setup[AW:1];
                rd_en      = 1'b1;
                rd_addr    = sum_setup[AW:1];
                state_next = S_BIN;
            end
            S_BIN:
            begin
                if (key_eq)
                begin
                    result_valid_next    = 1'b1;
                    result_next.found    = 1'b1;
                    result_next.position = est_pkg::POS_W'(mid_reg);
                    state_next           = S_IDLE;
                end
                else if ((key_gt && (mid_reg == hi_reg)) || (!key_gt && (mid_reg == lo_reg)))
                begin
                    // The range has closed without a match.
                    result_valid_next    = 1'b1;
                    result_next.found    = 1'b0;
                    result_next.position = est_pkg::POS_W'(n_reg);
                    state_next           = S_IDLE;
                end
                else if (key_gt)
                begin
                    lo_next  = mid_plus;
                    mid_next = sum_up[AW:1];
                    rd_en    = 1'b1;
                    rd_addr  = sum_up[AW:1];
                end
                else
                begin
                    hi_next  = mid_minus;
                    mid_next = sum_down[AW:1];
                    rd_en    = 1'b1;
                    rd_addr  = sum_down[AW:1];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        step_reg   <= step_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        result_reg <= result_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/est_checker.sv =====
module est_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input est_pkg::req_t             req,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [est_pkg::POS_W-1:0] cfg_data,
    input logic                      result_valid,
    input est_pkg::rsp_t             result
);

    // A write transfer finishes in its own cycle and never yields a result.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == est_pkg::REQ_WRITE)) |=> (!busy && !result_valid))
        else $error("write request left the block busy or produced a result");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted request");

    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("search ended without a result");

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while a search is still running");

endmodule

bind exponential_search_sorted_table est_checker u_est_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
);
